// ===== hdl/cle_pkg.sv =====
// Package for the console line editor: sizes, character codes, beat kinds,
// controller states and the structs passed between the top level and the editor.
// No dependencies.
package cle_pkg;

    localparam int LINE_WIDTH = 64;
    localparam int IDX_W      = $clog2(LINE_WIDTH);
    localparam int CNT_W      = $clog2(LINE_WIDTH + 1);
    localparam int ADDR_W     = IDX_W + 1;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_BRACK = 8'h5B;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPD   = 8'h44;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TAKE = 1'b1;

    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_LINE   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_NONE      = 2'd1,
        ST_TOO_LONG  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ECHO,
        S_LOAD,
        S_LINE
    } t_state;

    // Editing state kept in flops by the top level.
    typedef struct packed {
        logic [CNT_W-1:0] wi;
        logic             too_long;
        logic             esc;
        logic             brk;
    } t_edit_state;

    // Actions the editor asks of the top level for one received byte.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] widx;
        logic             commit;
        logic [CNT_W-1:0] len;
        logic             echo_one;
        logic             echo_bs;
    } t_edit_ctl;

endpackage

// ===== hdl/cle_edit.sv =====
// Line editing rules for one received byte: next editing state and actions.
// Depends on cle_pkg.
module cle_edit (
    input  cle_pkg::t_edit_state i_state,
    input  logic                 i_pending,
    input  logic [7:0]           i_byte,
    output cle_pkg::t_edit_state o_state,
    output cle_pkg::t_edit_ctl   o_ctl
);

    logic stores;
    logic is_bs;
    logic is_eol;
    logic [cle_pkg::CNT_W-1:0] wi1;

    assign is_bs  = (i_byte == cle_pkg::CH_BS);
    assign is_eol = (i_byte == cle_pkg::CH_CR) || (i_byte == cle_pkg::CH_LF);
    assign stores = ((i_byte >= cle_pkg::CH_SP) && (i_byte <= cle_pkg::CH_DEL)) ||
                    is_bs || is_eol;

    always_comb begin
        o_state      = i_state;
        o_ctl        = '0;
        o_ctl.widx   = i_state.wi[cle_pkg::IDX_W-1:0];
        wi1          = i_state.wi;

        // store and advance
        if (stores && !i_state.esc) begin
            o_ctl.we = 1'b1;
            wi1      = i_state.wi + cle_pkg::CNT_W'(1);
        end

        priority if (is_bs) begin
            if ((wi1 >= cle_pkg::CNT_W'(2)) && !i_state.esc) begin
                wi1           = wi1 - cle_pkg::CNT_W'(2);
                o_ctl.echo_bs = 1'b1;
            end else begin
                wi1 = '0;
            end
        end else if (is_eol) begin
            if (!i_pending && (wi1 > cle_pkg::CNT_W'(1)) && !i_state.esc) begin
                o_ctl.commit = 1'b1;
                o_ctl.len    = wi1 - cle_pkg::CNT_W'(1);
                wi1          = '0;
            end
        end else if (i_byte == cle_pkg::CH_ESC) begin
            o_state.esc = 1'b1;
        end else if (i_state.esc) begin
            if (i_state.brk) begin
                if ((i_byte >= cle_pkg::CH_UPA) && (i_byte <= cle_pkg::CH_UPD)) begin
                    o_state.esc = 1'b0;
                    o_state.brk = 1'b0;
                end
            end else if (i_byte == cle_pkg::CH_BRACK) begin
                o_state.brk = 1'b1;
            end
        end else begin
            o_ctl.echo_one = 1'b1;
        end

        // overfull line: drop it
        if (wi1 >= cle_pkg::CNT_W'(cle_pkg::LINE_WIDTH)) begin
            wi1              = '0;
            o_state.too_long = 1'b1;
        end
        o_state.wi = wi1;
    end

endmodule

// ===== hdl/console_line_editor_top.sv =====
// Console line editor top level: handshakes, line/entry memory, beat sequencer.
// Depends on cle_pkg and cle_edit.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser = req_type, tdata[7:0] = rx_byte
//  m_axis    out  m_axis_tvalid/tready      tuser = out_kind, tdata[7:0] = out_byte,
//                                           tdata[9:8] = line_status, tlast = last
//  cfg       in   i_cfg_we (no wait)        i_cfg_wdata = console_enable
//
// The echo beats of a received byte (none, one, or BS SP BS) leave one per
// cycle while the sink is ready. A take request streams the pending line byte
// by byte: a memory read, then a load of the output register. A new item is
// taken once the previous item's last beat is leaving; after a streamed line,
// in the cycle after its last beat has left.
// Reset (synchronous, active low) clears control state only; memory
// contents need no clearing pass. A stalled sink holds the output register.
module console_line_editor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] line_status, zero above
    output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
    output logic        m_axis_tlast
);

    // The memory holds two banks: one is the line being edited, the other the
    // pending entry. Closing a line flips the bank select instead of copying;
    // every index below the write index was written since it last was zero.
    logic [7:0] mem [0:(1 << cle_pkg::ADDR_W)-1];

    cle_pkg::t_state      r_state,    n_state;
    cle_pkg::t_edit_state r_edit,     n_edit;
    logic                 r_pending,  n_pending;
    logic [cle_pkg::CNT_W-1:0] r_len, n_len;
    logic                 r_bank,     n_bank;      // bank holding the line being edited
    logic                 r_started,  n_started;
    logic                 r_enable,   n_enable;
    logic                 r_echo_step, n_echo_step;
    logic [cle_pkg::IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic                 r_ovalid,   n_ovalid;
    cle_pkg::t_kind       r_okind,    n_okind;
    logic [7:0]           r_obyte,    n_obyte;
    cle_pkg::t_status     r_ostatus,  n_ostatus;
    logic                 r_olast,    n_olast;
    logic [7:0]           r_rd_data;

    cle_pkg::t_edit_state edit_next;
    cle_pkg::t_edit_ctl   edit_ctl;
    logic                 out_free;
    logic                 in_accept;
    logic                 mem_we;
    logic [cle_pkg::ADDR_W-1:0] rd_addr;

    cle_edit u_edit (
        .i_state   (r_edit),
        .i_pending (r_pending),
        .i_byte    (s_axis_tdata),
        .o_state   (edit_next),
        .o_ctl     (edit_ctl)
    );

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == cle_pkg::S_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Write the line bank only for a processed byte that the editor stores.
    assign mem_we = in_accept && (s_axis_tuser == cle_pkg::REQ_BYTE) && r_started &&
                    r_enable && edit_ctl.we;

    // Read the entry bank every cycle; the read data is registered. Reads and
    // writes always hit different banks while a line streams out.
    assign rd_addr = {~r_bank, n_rd_idx};

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {6'b0, r_ostatus, r_obyte};
    assign m_axis_tlast  = r_olast;

    always_comb begin
        n_state     = r_state;
        n_edit      = r_edit;
        n_pending   = r_pending;
        n_len       = r_len;
        n_bank      = r_bank;
        n_started   = r_started;
        n_enable    = r_enable;
        n_echo_step = r_echo_step;
        n_rd_idx    = r_rd_idx;
        n_ovalid    = r_ovalid;
        n_okind     = r_okind;
        n_obyte     = r_obyte;
        n_ostatus   = r_ostatus;
        n_olast     = r_olast;

        if (i_cfg_we) begin
            n_enable = i_cfg_wdata;
        end

        unique case (r_state)
            cle_pkg::S_IDLE: begin
                if (out_free) begin
                    n_ovalid = 1'b0;
                end
                n_rd_idx = '0;
                if (in_accept) begin
                    if (s_axis_tuser == cle_pkg::REQ_TAKE) begin
                        n_pending = 1'b0;
                        if (r_pending) begin
                            n_state = cle_pkg::S_LOAD;
                        end else begin
                            n_ovalid  = 1'b1;
                            n_okind   = cle_pkg::KIND_STATUS;
                            n_obyte   = 8'h00;
                            n_olast   = 1'b1;
                            if (r_edit.too_long) begin
                                n_ostatus       = cle_pkg::ST_TOO_LONG;
                                n_edit.too_long = 1'b0;
                            end else begin
                                n_ostatus = cle_pkg::ST_NONE;
                            end
                        end
                    end else if (!r_started) begin
                        // swallow the first byte after reset
                        n_started = 1'b1;
                        n_edit.wi = '0;
                        n_enable  = 1'b1;
                    end else if (r_enable) begin
                        n_edit = edit_next;
                        if (edit_ctl.commit) begin
                            n_len     = edit_ctl.len;
                            n_pending = 1'b1;
                            n_bank    = ~r_bank;
                        end
                        n_okind   = cle_pkg::KIND_ECHO;
                        n_ostatus = cle_pkg::ST_DELIVERED;
                        if (edit_ctl.echo_bs) begin
                            n_ovalid    = 1'b1;
                            n_obyte     = cle_pkg::CH_BS;
                            n_olast     = 1'b0;
                            n_echo_step = 1'b0;
                            n_state     = cle_pkg::S_ECHO;
                        end else if (edit_ctl.echo_one) begin
                            n_ovalid = 1'b1;
                            n_obyte  = s_axis_tdata;
                            n_olast  = 1'b1;
                        end
                    end
                end
            end
            cle_pkg::S_ECHO: begin
                // advance through space, then the closing backspace
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (!r_echo_step) begin
                        n_obyte     = cle_pkg::CH_SP;
                        n_olast     = 1'b0;
                        n_echo_step = 1'b1;
                    end else begin
                        n_obyte = cle_pkg::CH_BS;
                        n_olast = 1'b1;
                        n_state = cle_pkg::S_IDLE;
                    end
                end
            end
            cle_pkg::S_LOAD: begin
                n_ovalid  = 1'b1;
                n_okind   = cle_pkg::KIND_LINE;
                n_obyte   = r_rd_data;
                n_ostatus = cle_pkg::ST_DELIVERED;
                n_olast   = (cle_pkg::CNT_W'(r_rd_idx) + cle_pkg::CNT_W'(1)) == r_len;
                n_state   = cle_pkg::S_LINE;
            end
            cle_pkg::S_LINE: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_state = cle_pkg::S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + cle_pkg::IDX_W'(1);
                        n_state  = cle_pkg::S_LOAD;
                    end
                end
            end
            default: begin
                n_state = cle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::S_IDLE;
            r_edit      <= '0;
            r_pending   <= 1'b0;
            r_len       <= '0;
            r_bank      <= 1'b0;
            r_started   <= 1'b0;
            r_enable    <= 1'b1;
            r_echo_step <= 1'b0;
            r_rd_idx    <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_edit      <= n_edit;
            r_pending   <= n_pending;
            r_len       <= n_len;
            r_bank      <= n_bank;
            r_started   <= n_started;
            r_enable    <= n_enable;
            r_echo_step <= n_echo_step;
            r_rd_idx    <= n_rd_idx;
            r_ovalid    <= n_ovalid;
        end
    end

    // Output payload holds while stalled; no reset needed.
    always_ff @(posedge i_clk) begin
        r_okind   <= n_okind;
        r_obyte   <= n_obyte;
        r_ostatus <= n_ostatus;
        r_olast   <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[{r_bank, edit_ctl.widx}] <= s_axis_tdata;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/cle_checker.sv =====
// Port-level checks for the console line editor output stream, bound to the top.
// Depends on console_line_editor_top's port names.
module cle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // A status beat stands alone, carries no byte and a real status.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == 2'd2) |->
        m_axis_tlast && (m_axis_tdata[7:0] == 8'h00) &&
        ((m_axis_tdata[9:8] == 2'd1) || (m_axis_tdata[9:8] == 2'd2)))
        else $error("malformed status beat");

    // Echo and line beats report status zero; padding stays zero; kind 3 never shows.
    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:10] == 6'd0) && (m_axis_tuser != 2'd3) &&
        ((m_axis_tuser == 2'd2) || (m_axis_tdata[9:8] == 2'd0)))
        else $error("bad payload on output beat");

    // A line beat that is not the last is followed by more line beats only.
    a_line_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && (m_axis_tuser == 2'd1) && !m_axis_tlast |=>
        !m_axis_tvalid || (m_axis_tuser == 2'd1))
        else $error("line run interrupted");

endmodule

bind console_line_editor_top cle_checker u_cle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/console_line_editor_checker.sv =====
`timescale 1ns / 100ps
// Checker for the console line editor: watches the input, config and result channels,
// predicts every result beat of each accepted item and compares it field by field.
// Depends on cle_pkg.
module console_line_editor_checker
    import cle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        t_kind      kind;
        logic [7:0] chr;
        t_status    status;
        logic       last;
    } t_result_beat;

    t_result_beat expected_beats[$];

    // Shadow of the editor state.
    logic [7:0]  line_mem  [LINE_WIDTH];
    logic [7:0]  entry_mem [LINE_WIDTH];
    int unsigned wr_idx;
    int unsigned entry_len;
    bit          entry_pending;
    bit          overflowed;
    bit          in_escape;
    bit          in_bracket;
    bit          started;
    bit          console_on;
    int          mismatches = 0;

    function automatic void push_beat(t_kind k, logic [7:0] c, t_status s, logic l);
        t_result_beat b;
        b.kind   = k;
        b.chr    = c;
        b.status = s;
        b.last   = l;
        expected_beats.push_back(b);
    endfunction

    task automatic edit_byte(input logic [7:0] c);
        bit keeps;
        keeps = (c >= CH_SP && c <= CH_DEL) || c == CH_CR || c == CH_BS || c == CH_LF;
        if (keeps && !in_escape) begin
            if (wr_idx < LINE_WIDTH) line_mem[wr_idx] = c;
            wr_idx++;
        end
        if (c == CH_BS) begin
            if (wr_idx >= 2 && !in_escape) begin
                wr_idx -= 2;
                push_beat(KIND_ECHO, CH_BS, ST_DELIVERED, 1'b0);
                push_beat(KIND_ECHO, CH_SP, ST_DELIVERED, 1'b0);
                push_beat(KIND_ECHO, CH_BS, ST_DELIVERED, 1'b1);
            end else begin
                wr_idx = 0;
            end
        end else if (c == CH_CR || c == CH_LF) begin
            if (!entry_pending && wr_idx > 1 && !in_escape) begin
                entry_len = wr_idx - 1;
                if (entry_len > LINE_WIDTH) entry_len = LINE_WIDTH;
                for (int i = 0; i < entry_len; i++) entry_mem[i] = line_mem[i];
                wr_idx        = 0;
                entry_pending = 1'b1;
            end
        end else if (c == CH_ESC) begin
            in_escape = 1'b1;
        end else if (in_escape) begin
            if (in_bracket) begin
                if (c >= CH_UPA && c <= CH_UPD) begin
                    in_escape  = 1'b0;
                    in_bracket = 1'b0;
                end
            end else if (c == CH_BRACK) begin
                in_bracket = 1'b1;
            end
        end else begin
            push_beat(KIND_ECHO, c, ST_DELIVERED, 1'b1);
        end
        if (wr_idx >= LINE_WIDTH) begin
            wr_idx     = 0;
            overflowed = 1'b1;
        end
    endtask

    task automatic take_line();
        if (entry_pending && entry_len > 0) begin
            for (int i = 0; i < entry_len; i++)
                push_beat(KIND_LINE, entry_mem[i], ST_DELIVERED, (i + 1 == entry_len));
        end else if (overflowed) begin
            overflowed = 1'b0;
            push_beat(KIND_STATUS, 8'h00, ST_TOO_LONG, 1'b1);
        end else begin
            push_beat(KIND_STATUS, 8'h00, ST_NONE, 1'b1);
        end
        entry_pending = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_result_beat exp_beat;
        if (!i_rst_n) begin
            expected_beats.delete();
            wr_idx        = 0;
            entry_len     = 0;
            entry_pending = 1'b0;
            overflowed    = 1'b0;
            in_escape     = 1'b0;
            in_bracket    = 1'b0;
            started       = 1'b0;
            console_on    = 1'b1;
        end else begin
            // Compare the leaving beat before anything accepted at this edge is queued.
            if (i_m_tvalid && i_m_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat: tuser %0d tdata %h tlast %0b",
                           i_m_tuser, i_m_tdata, i_m_tlast);
                    mismatches++;
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (i_m_tuser !== exp_beat.kind) begin
                        $error("out_kind: expected %0d, got %0d", exp_beat.kind, i_m_tuser);
                        mismatches++;
                    end
                    if (i_m_tdata[7:0] !== exp_beat.chr) begin
                        $error("out_byte: expected %h, got %h", exp_beat.chr, i_m_tdata[7:0]);
                        mismatches++;
                    end
                    if (i_m_tdata[9:8] !== exp_beat.status) begin
                        $error("line_status: expected %0d, got %0d",
                               exp_beat.status, i_m_tdata[9:8]);
                        mismatches++;
                    end
                    if (i_m_tdata[15:10] !== 6'd0) begin
                        $error("tdata padding: expected 0, got %h", i_m_tdata[15:10]);
                        mismatches++;
                    end
                    if (i_m_tlast !== exp_beat.last) begin
                        $error("last: expected %0b, got %0b", exp_beat.last, i_m_tlast);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) console_on = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == REQ_TAKE) begin
                    take_line();
                end else begin
                    if (started && console_on) edit_byte(i_s_tdata);
                    if (!started) begin
                        started    = 1'b1;
                        wr_idx     = 0;
                        console_on = 1'b1;
                    end
                end
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= expected_beats.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the console line editor testbench: clock, reset, stimulus and verdict.
// Depends on cle_pkg, console_line_editor_top and console_line_editor_checker.
module testbench;
    import cle_pkg::*;

    // Timeout in cycles: worst case is far below this even with every take
    // streaming a full line against the slowest sink.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int LONG_HOLD   = 500;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int outstanding;
    int item_count  = 0;
    int cycle_count = 0;
    bit tx_dense    = 1'b0;
    bit hold_req    = 1'b0;

    console_line_editor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    console_line_editor_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tlast     (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Drive every input to a known value from time zero.
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = REQ_BYTE;
        m_axis_tready = 1'b0;
    end

    // Sink: draw a wait per beat, switch into stretches with no waiting now and
    // then, and hold off once for a long stretch when asked, so the block backs up.
    initial begin
        int  rx_wait   = 0;
        int  hold_left = 0;
        bit  hold_done = 1'b0;
        bit  rx_dense  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if ($urandom_range(0, 63) == 0) rx_dense = !rx_dense;
                rx_wait = rx_dense ? 0 : $urandom_range(0, 11);
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (rx_wait > 0) begin
                m_axis_tready = 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Cycle counter: end the run if it hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one beat after a random gap and hold it until accepted. Returns at the
    // falling edge after acceptance with tvalid still high; the next call either
    // replaces the data or drops tvalid.
    task automatic send_item(input logic typ, input logic [7:0] chr);
        int gap;
        gap = tx_dense ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = typ;
        s_axis_tdata  = chr;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        item_count++;
    endtask

    // Wait for the last expected beat, then wait on so that items which
    // produce nothing have also left the block.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_console(input logic on);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = on;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // A typed line: mostly short, now and then long enough to overflow; edited
    // with backspaces and cursor keys, closed by CR or LF.
    task automatic type_line();
        int len;
        int p;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
            p = $urandom_range(0, 99);
            if (p < 8) begin
                send_item(REQ_BYTE, CH_BS);
            end else if (p < 12) begin
                send_item(REQ_BYTE, CH_ESC);
                send_item(REQ_BYTE, CH_BRACK);
                send_item(REQ_BYTE, 8'($urandom_range(CH_UPA, CH_UPD)));
            end else begin
                send_item(REQ_BYTE, 8'($urandom_range(CH_SP, CH_DEL)));
            end
        end
        send_item(REQ_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    // One random segment: mostly well-formed lines and takes, the rest noise,
    // broken escapes and runs of backspace.
    task automatic random_segment();
        int r;
        tx_dense = ($urandom_range(0, 5) == 0);
        r = $urandom_range(0, 99);
        if (r < 55) begin
            type_line();
        end else if (r < 75) begin
            send_item(REQ_TAKE, 8'($urandom));
        end else if (r < 88) begin
            send_item(REQ_BYTE, 8'($urandom_range(0, 255)));
        end else if (r < 95) begin
            send_item(REQ_BYTE, CH_ESC);
            if ($urandom_range(0, 1)) send_item(REQ_BYTE, CH_BRACK);
            send_item(REQ_BYTE, 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) send_item(REQ_BYTE, CH_BS);
        end
    endtask

    initial begin
        int target;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Disable first: the swallowed first byte must turn the console back on.
        set_console(1'b0);
        send_item(REQ_BYTE, 8'hFF);
        send_item(REQ_TAKE, 8'h00);        // nothing pending
        send_item(REQ_BYTE, 8'h68);
        send_item(REQ_BYTE, 8'h69);
        send_item(REQ_BYTE, CH_BS);        // erase with echo
        send_item(REQ_BYTE, CH_BS);        // erase the first byte
        send_item(REQ_BYTE, CH_BS);        // empty line: no echo
        send_item(REQ_BYTE, CH_CR);        // empty line: CR kept in buffer
        send_item(REQ_BYTE, CH_LF);        // closes a line holding only the CR
        send_item(REQ_TAKE, 8'h00);
        send_item(REQ_BYTE, CH_ESC);       // cursor key, silent
        send_item(REQ_BYTE, CH_BRACK);
        send_item(REQ_BYTE, CH_UPA);
        send_item(REQ_BYTE, CH_ESC);       // junk inside escape, then cursor key
        send_item(REQ_BYTE, 8'h71);
        send_item(REQ_BYTE, CH_BRACK);
        send_item(REQ_BYTE, CH_UPD);
        send_item(REQ_BYTE, 8'h00);        // non-printables echo but do not store
        send_item(REQ_BYTE, CH_DEL);
        send_item(REQ_BYTE, 8'h80);
        send_item(REQ_BYTE, 8'hFF);
        send_item(REQ_BYTE, CH_SP);
        send_item(REQ_BYTE, CH_CR);        // commit DEL, space
        send_item(REQ_BYTE, 8'h7A);
        send_item(REQ_BYTE, CH_LF);        // entry pending: line stays
        send_item(REQ_TAKE, 8'h00);
        send_item(REQ_TAKE, 8'h00);

        // Enabled, random; one long sink hold-off partway through.
        set_console(1'b1);
        target = item_count + 200;
        while (item_count < target) begin
            if (!hold_req && item_count > target - 150) hold_req = 1'b1;
            random_segment();
        end

        // Disabled: bytes vanish, takes still answer.
        set_console(1'b0);
        repeat (10) random_segment();

        set_console(1'b1);
        target = item_count + 150;
        while (item_count < target) random_segment();

        // Drain, then let the pipeline settle before the verdict.
        s_axis_tvalid = 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== console_line_editor_top.f =====
hdl/cle_pkg.sv
hdl/cle_edit.sv
hdl/console_line_editor_top.sv
hdl/cle_checker.sv
tb/console_line_editor_checker.sv
tb/testbench.sv
